[hw/rtl/ppq_pkg.sv]
// Package: shared constants, codes and types of the Paxos proposer quorum block.
`default_nettype none
package ppq_pkg;
    localparam int NODES       = 16;
    localparam int NODE_W      = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PROM_W      = 129;
    localparam logic [63:0] BALLOT_STEP = 64'h0000_0000_0001_0000;

    typedef enum logic [2:0] {
        F_PREPARE  = 3'd0,
        F_RESTART  = 3'd1,
        F_PROMISE  = 3'd2,
        F_ACCEPTED = 3'd3,
        F_DIE      = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        V_ISSUED     = 3'd0,
        V_DROP       = 3'd1,
        V_NOT_ENOUGH = 3'd2,
        V_CONTINUE   = 3'd3,
        V_RESTART    = 3'd4,
        V_CHOOSE     = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_NODE_ID  = 2'd0,
        CFG_RQUORUM  = 2'd1,
        CFG_WQUORUM  = 2'd2,
        CFG_INIT_VAL = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_P,
        S_SCAN_P_LAST,
        S_SCAN_A,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  sender_node;
        logic [63:0] ack_ballot;
        logic        reply;
        logic [63:0] accepted_ballot;
        logic [63:0] accepted_value_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [63:0] ballot_out;
        logic [63:0] value_id_out;
        logic        value_valid;
    } t_out;
endpackage
`default_nettype wire

[hw/rtl/ppq_if.sv]
// Interface: valid/ready channel carrying one payload item.
`default_nettype none
interface ppq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ppq_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module ppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/paxos_proposer_quorum_top.sv]
// Top level: Paxos proposer with per-sender acknowledgement tables held in RAM.
//
//  channel   dir  payload                                               handshake
//  s_in      in   func, sender_node, ack_ballot, reply, accepted_*      valid/ready
//  m_out     out  verdict, ballot_out, value_id_out, value_valid        valid/ready
//  cfg       in   i_cfg_idx, i_cfg_data                                 i_cfg_we
//
// Prepare, restart, die-clean and dropped items pass through S_DONE, which registers the result.
// An ack that reaches quorum rescans its table at one RAM read per cycle.
// The single RAM read port of each table sets the rescan length.
// Reset clears control state and the present bits; no clearing pass is needed.
// One item is in flight at a time; a stalled result holds until taken.
`default_nettype none
module paxos_proposer_quorum_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ppq_if.sink                                s_in,
    ppq_if.source                              m_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ppq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ppq_pkg::CFG_W-1:0]     i_cfg_data
);
    // configuration
    logic [15:0] r_node_id;
    logic [4:0]  r_rq, r_wq;
    logic [63:0] r_init_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id  <= '0;
            r_rq       <= 5'd9;
            r_wq       <= 5'd9;
            r_init_val <= '0;
        end else if (i_cfg_we) begin
            case (ppq_pkg::t_cfg_idx'(i_cfg_idx))
                ppq_pkg::CFG_NODE_ID:  r_node_id  <= i_cfg_data[15:0];
                ppq_pkg::CFG_RQUORUM:  r_rq       <= i_cfg_data[4:0];
                ppq_pkg::CFG_WQUORUM:  r_wq       <= i_cfg_data[4:0];
                ppq_pkg::CFG_INIT_VAL: r_init_val <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // proposer state
    logic [63:0] r_ballot, r_val, r_hi_bal, r_hi_val;
    logic        r_val_held, r_hi_held;
    logic [ppq_pkg::NODES-1:0] r_p_pres, r_a_pres;
    logic [ppq_pkg::CNT_W-1:0] r_p_cnt, r_a_cnt, r_yes;
    ppq_pkg::t_state r_state, n_state;
    logic [ppq_pkg::NODE_W:0] r_idx;
    logic [ppq_pkg::NODE_W-1:0] r_ridx;
    logic        r_ovalid;
    ppq_pkg::t_verdict r_verdict;

    // RAM for promise data (yes, acc ballot, acc value) and accept yes bits
    logic                         p_we, a_we;
    logic [ppq_pkg::PROM_W-1:0]   p_rdata;
    logic [0:0]                   a_rdata;
    logic [ppq_pkg::NODE_W-1:0]   ram_raddr;

    assign ram_raddr = r_idx[ppq_pkg::NODE_W-1:0];

    ppq_ram #(.WIDTH(ppq_pkg::PROM_W), .DEPTH(ppq_pkg::NODES)) u_prom_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(s_in.data.sender_node),
        .i_wdata({s_in.data.reply, s_in.data.accepted_ballot, s_in.data.accepted_value_id}),
        .i_raddr(ram_raddr),
        .o_rdata(p_rdata)
    );

    ppq_ram #(.WIDTH(1), .DEPTH(ppq_pkg::NODES)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr(s_in.data.sender_node),
        .i_wdata(s_in.data.reply),
        .i_raddr(ram_raddr),
        .o_rdata(a_rdata)
    );

    // accept / drop decode
    logic acc_in, stale, p_ok, a_ok;
    logic [ppq_pkg::NODES-1:0] sender_bit;
    logic p_new, a_new;
    assign acc_in     = s_in.valid && s_in.ready;
    assign stale      = s_in.data.ack_ballot < r_ballot;
    assign sender_bit = ppq_pkg::NODES'(1) << s_in.data.sender_node;
    assign p_ok = (ppq_pkg::t_func'(s_in.data.func) == ppq_pkg::F_PROMISE) && !stale && !r_val_held;
    assign a_ok = (ppq_pkg::t_func'(s_in.data.func) == ppq_pkg::F_ACCEPTED) && !stale && r_val_held;
    assign p_we = acc_in && p_ok;
    assign a_we = acc_in && a_ok;
    assign p_new = (r_p_pres & sender_bit) == '0;
    assign a_new = (r_a_pres & sender_bit) == '0;
    assign s_in.ready = (r_state == ppq_pkg::S_IDLE) && !r_ovalid;

    // next ballot
    logic [63:0] nb;
    assign nb = (r_ballot == '0) ? (ppq_pkg::BALLOT_STEP + {48'd0, r_node_id})
                                 : (r_ballot + ppq_pkg::BALLOT_STEP);

    // scan element from the previous read address
    logic        s_pres, s_yes;
    logic [63:0] s_bal, s_val;
    assign s_pres = r_p_pres[r_ridx];
    assign s_yes  = p_rdata[ppq_pkg::PROM_W-1];
    assign s_bal  = p_rdata[127:64];
    assign s_val  = p_rdata[63:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppq_pkg::S_IDLE: begin
                if (acc_in) begin
                    if (p_ok && ({1'b0, r_p_cnt} + {5'd0, p_new}) >= {1'b0, r_rq})
                        n_state = ppq_pkg::S_SCAN_P;
                    else if (a_ok && ({1'b0, r_a_cnt} + {5'd0, a_new}) >= {1'b0, r_wq})
                        n_state = ppq_pkg::S_SCAN_A;
                    else
                        n_state = ppq_pkg::S_DONE;
                end
            end
            ppq_pkg::S_SCAN_P:
                if (r_idx == 5'(ppq_pkg::NODES)) n_state = ppq_pkg::S_SCAN_P_LAST;
            ppq_pkg::S_SCAN_P_LAST: n_state = ppq_pkg::S_IDLE;
            ppq_pkg::S_SCAN_A:
                if (r_idx == 5'(ppq_pkg::NODES)) n_state = ppq_pkg::S_SCAN_P_LAST;
            ppq_pkg::S_DONE: n_state = ppq_pkg::S_IDLE;
            default: n_state = ppq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ppq_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // datapath: execute, scan and decide
    logic        is_prom_scan;
    logic        r_scan_p;
    assign is_prom_scan = r_scan_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ballot   <= '0;
            r_val      <= '0;
            r_val_held <= 1'b0;
            r_hi_bal   <= '0;
            r_hi_val   <= '0;
            r_hi_held  <= 1'b0;
            r_p_pres   <= '0;
            r_a_pres   <= '0;
            r_p_cnt    <= '0;
            r_a_cnt    <= '0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_ridx     <= '0;
            r_yes      <= '0;
            r_scan_p   <= 1'b0;
            r_verdict  <= ppq_pkg::V_ISSUED;
        end else begin
            r_ridx <= ram_raddr;
            case (r_state)
                ppq_pkg::S_IDLE: begin
                    r_idx <= '0;
                    r_yes <= '0;
                    // drop the result once it is taken
                    if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
                    if (acc_in) begin
                        case (ppq_pkg::t_func'(s_in.data.func))
                            ppq_pkg::F_PREPARE: begin
                                r_ballot  <= nb;
                                r_verdict <= ppq_pkg::V_ISSUED;
                            end
                            ppq_pkg::F_RESTART: begin
                                r_ballot   <= nb;
                                r_val      <= '0;
                                r_val_held <= 1'b0;
                                r_p_pres   <= '0;
                                r_a_pres   <= '0;
                                r_p_cnt    <= '0;
                                r_a_cnt    <= '0;
                                r_verdict  <= ppq_pkg::V_ISSUED;
                            end
                            ppq_pkg::F_DIE: begin
                                r_ballot   <= '0;
                                r_val      <= '0;
                                r_val_held <= 1'b0;
                                r_p_pres   <= '0;
                                r_a_pres   <= '0;
                                r_p_cnt    <= '0;
                                r_a_cnt    <= '0;
                                r_verdict  <= ppq_pkg::V_ISSUED;
                            end
                            ppq_pkg::F_PROMISE: begin
                                if (p_ok) begin
                                    r_p_pres  <= r_p_pres | sender_bit;
                                    r_p_cnt   <= r_p_cnt + {4'd0, p_new};
                                    r_verdict <= ppq_pkg::V_NOT_ENOUGH;
                                    r_scan_p  <= 1'b1;
                                end else begin
                                    r_verdict <= ppq_pkg::V_DROP;
                                end
                            end
                            ppq_pkg::F_ACCEPTED: begin
                                if (a_ok) begin
                                    r_a_pres  <= r_a_pres | sender_bit;
                                    r_a_cnt   <= r_a_cnt + {4'd0, a_new};
                                    r_verdict <= ppq_pkg::V_NOT_ENOUGH;
                                    r_scan_p  <= 1'b0;
                                end else begin
                                    r_verdict <= ppq_pkg::V_DROP;
                                end
                            end
                            default: r_verdict <= ppq_pkg::V_DROP;
                        endcase
                    end
                end
                ppq_pkg::S_SCAN_P, ppq_pkg::S_SCAN_A: begin
                    // issue next read, fold the data from the previous one
                    r_idx <= r_idx + 5'd1;
                    if (r_idx != '0) begin
                        if (is_prom_scan) begin
                            if (s_pres && s_yes) begin
                                r_yes <= r_yes + 5'd1;
                                if (s_bal > r_hi_bal) begin
                                    r_hi_bal  <= s_bal;
                                    r_hi_val  <= s_val;
                                    r_hi_held <= 1'b1;
                                end
                            end
                        end else if (r_a_pres[r_ridx] && a_rdata[0]) begin
                            r_yes <= r_yes + 5'd1;
                        end
                    end
                end
                ppq_pkg::S_SCAN_P_LAST: begin
                    r_ovalid <= 1'b1;
                    if (is_prom_scan) begin
                        if (r_yes >= r_rq) begin
                            r_val      <= r_hi_held ? r_hi_val : r_init_val;
                            r_val_held <= 1'b1;
                            r_verdict  <= ppq_pkg::V_CONTINUE;
                        end else begin
                            r_verdict  <= ppq_pkg::V_RESTART;
                        end
                    end else begin
                        r_verdict <= (r_yes >= r_wq) ? ppq_pkg::V_CHOOSE
                                                     : ppq_pkg::V_RESTART;
                    end
                end
                ppq_pkg::S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // result fields follow the live state once the item is done
    assign m_out.valid             = r_ovalid;
    assign m_out.data.verdict      = r_verdict;
    assign m_out.data.ballot_out   = r_ballot;
    assign m_out.data.value_id_out = r_val_held ? r_val : '0;
    assign m_out.data.value_valid  = r_val_held;

    // checks
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_in.ready) else $error("input taken while result pending");
    a_cnt_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_cnt == 5'($countones(r_p_pres))) else $error("promise count mismatch");
    a_cnt_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_cnt == 5'($countones(r_a_pres))) else $error("accept count mismatch");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppq_pkg::S_SCAN_P_LAST) |=> r_ovalid) else $error("scan gave no result");
endmodule
`default_nettype wire
